/* rtl/srdg_pkg.sv */
package srdg_pkg;

  localparam int DELAY_W     = 16;
  localparam int COUNT_WIDTH = 16;
  // Remainder and divisor hold 4*count-1
  localparam int REM_W       = COUNT_WIDTH + 2;
  // Dividend 2*prev + rem
  localparam int NUM_W       = ((REM_W > DELAY_W + 1) ? REM_W : DELAY_W + 1) + 1;
  localparam int DIV_CNT_W   = $clog2(NUM_W);
  localparam int CFG_IDX_W   = 3;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_STEPS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_COUNT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_STEPS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_DELAY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_DELAY = 3'd4;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 16'hFFFF;
  localparam logic [DELAY_W-1:0] DELAY_MIN   = 16'd2;
  localparam logic [DELAY_W-1:0] DELAY_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_WRITE
  } state_t;

  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/stepper_ramp_delay_generator.sv */
// Stepper ramp delay generator: one timer reload value per request.
// Configure over cfg_we/cfg_addr/cfg_wdata while idle: 0 total_steps,
// 1 accel_count, 2 cruise_steps, 3 first_delay, 4 cruise_delay.
// Request channel (s_*): s_tdata[0] = restart; 1 starts a new move at step 0,
// 0 asks for the next step. Result channel (m_*): m_tdata = delay,
// m_tlast marks the zero terminator sent after the final step.
// One request is in flight at a time. Cruise steps, the first accel step
// and the terminator pass from the accepting edge through the EVAL and
// WRITE states to the output register; accel and decel steps also pass
// through the bit-serial divider (19 quotient bits, one per cycle) that
// evaluates floor((2*prev + rem) / (4n - 1)).
// A new request is taken as soon as the previous result is in the output
// register, even while the receiver holds m_tready low; if the receiver
// still stalls when the next result is ready, the block waits with that
// result until the output register frees up.
// Reset (rst, synchronous) loads the register defaults and leaves the block
// with no move running: requests without restart return the terminator.
module stepper_ramp_delay_generator (
  input  logic                              clk,
  input  logic                              rst,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [srdg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [srdg_pkg::DELAY_W-1:0]      cfg_wdata,
  // request channel
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [srdg_pkg::S_TDATA_W-1:0]    s_tdata,   // [0] restart, [7:1] zero
  // result channel
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [srdg_pkg::M_TDATA_W-1:0]    m_tdata,   // [15:0] delay
  output logic                              m_tlast
);
  import srdg_pkg::*;

  cmd_t    cmd;
  status_t status;

  // control sequencing: accept, classify, divide, hand off
  srdg_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // move state, phase decode, divider and output register
  srdg_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .restart   (s_tdata[0]),
    .cmd       (cmd),
    .status    (status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_delay (m_tdata),
    .out_last  (m_tlast)
  );

  // terminator always carries a zero delay
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == '0)
    else $error("terminator with nonzero delay");

  // a regular step never reports a zero delay
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata != '0)
    else $error("zero delay on a regular step");

  // only one request in flight
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // results are only written after a request was taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !s_tready)
    else $error("result written while idle");

endmodule

/* rtl/srdg_div.sv */
module srdg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srdg_pkg::NUM_W-1:0]    dividend,
  input  logic [srdg_pkg::REM_W-1:0]    divisor,
  output logic [srdg_pkg::NUM_W-1:0]    quotient,
  output logic [srdg_pkg::REM_W-1:0]    remainder,
  output logic                          done
);
  import srdg_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     acc;
  logic [NUM_W-1:0]     quo;
  logic [REM_W-1:0]     dvs;
  logic [REM_W:0]       shifted;
  logic [REM_W:0]       diff;
  logic                 ge;

  // restoring division, one quotient bit per cycle
  assign shifted = {acc, quo[NUM_W-1]};
  assign ge      = shifted >= {1'b0, dvs};
  assign diff    = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      acc <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

  assign quotient  = quo;
  assign remainder = acc;

endmodule

/* rtl/srdg_dp.sv */
module srdg_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srdg_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [srdg_pkg::DELAY_W-1:0]      cfg_wdata,
  input  logic                              restart,
  input  srdg_pkg::cmd_t                    cmd,
  output srdg_pkg::status_t                 status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [srdg_pkg::DELAY_W-1:0]      out_delay,
  output logic                              out_last
);
  import srdg_pkg::*;

  logic [COUNT_WIDTH-1:0] total_steps;
  logic [COUNT_WIDTH-1:0] accel_count;
  logic [COUNT_WIDTH-1:0] cruise_steps;
  logic [DELAY_W-1:0]     first_delay;
  logic [DELAY_W-1:0]     cruise_delay;

  logic [COUNT_WIDTH-1:0] step_index;
  logic [DELAY_W-1:0]     previous_delay;
  logic [REM_W-1:0]       carry_remainder;
  logic                   move_done;

  logic                   is_term;
  logic                   in_accel;
  logic                   in_cruise;
  logic                   first_step;
  logic                   need_div;
  logic [COUNT_WIDTH:0]   accel_cruise_end;
  logic [COUNT_WIDTH-1:0] div_base;
  logic [REM_W-1:0]       divisor;
  logic [NUM_W-1:0]       dividend;
  logic [NUM_W-1:0]       quotient;
  logic [REM_W-1:0]       div_rem;
  logic                   div_done;
  logic [NUM_W-1:0]       grow_sum;
  logic [DELAY_W-1:0]     d_raw;
  logic [DELAY_W-1:0]     d_fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_steps  <= '0;
      accel_count  <= '0;
      cruise_steps <= '0;
      first_delay  <= DELAY_RESET;
      cruise_delay <= DELAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOTAL_STEPS:  total_steps  <= cfg_wdata[COUNT_WIDTH-1:0];
        REG_ACCEL_COUNT:  accel_count  <= cfg_wdata[COUNT_WIDTH-1:0];
        REG_CRUISE_STEPS: cruise_steps <= cfg_wdata[COUNT_WIDTH-1:0];
        REG_FIRST_DELAY:  first_delay  <= cfg_wdata;
        REG_CRUISE_DELAY: cruise_delay <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // phase decode
  assign is_term          = move_done || (step_index >= total_steps);
  assign in_accel         = step_index < accel_count;
  assign accel_cruise_end = {1'b0, accel_count} + {1'b0, cruise_steps};
  assign in_cruise        = !in_accel && ({1'b0, step_index} < accel_cruise_end);
  assign first_step       = step_index == '0;
  assign need_div         = !is_term && !in_cruise && !(in_accel && first_step);

  // accel divides by 4i-1, decel by 4m-1 with m steps left
  assign div_base = in_accel ? step_index : total_steps - step_index;
  assign divisor  = {div_base, 2'b00} - REM_W'(1);
  assign dividend = NUM_W'({previous_delay, 1'b0}) + NUM_W'(carry_remainder);

  srdg_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.start_div),
    .dividend  (dividend),
    .divisor   (divisor),
    .quotient  (quotient),
    .remainder (div_rem),
    .done      (div_done)
  );

  assign grow_sum = NUM_W'(previous_delay) + quotient;

  always_comb begin
    priority if (in_accel && first_step) begin
      d_raw = first_delay;
    end else if (in_accel) begin
      d_raw = (quotient >= NUM_W'(previous_delay)) ? '0
            : previous_delay - quotient[DELAY_W-1:0];
    end else if (in_cruise) begin
      d_raw = cruise_delay;
    end else begin
      d_raw = (grow_sum > NUM_W'(DELAY_MAX)) ? DELAY_MAX : grow_sum[DELAY_W-1:0];
    end
  end

  assign d_fin = (d_raw == '0) ? DELAY_MIN : d_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_index      <= '0;
      previous_delay  <= '0;
      carry_remainder <= '0;
      move_done       <= 1'b1;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load && restart) begin
        step_index      <= '0;
        carry_remainder <= '0;
        previous_delay  <= first_delay;
        move_done       <= 1'b0;
      end
      if (cmd.commit) begin
        if (is_term) begin
          move_done <= 1'b1;
        end else begin
          previous_delay <= d_fin;
          step_index     <= step_index + 1'b1;
          if (in_accel && first_step) begin
            carry_remainder <= '0;
          end else if (need_div) begin
            carry_remainder <= div_rem;
          end
        end
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_delay <= is_term ? '0 : d_fin;
      out_last  <= is_term;
    end
  end

  assign status.need_div = need_div;
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || out_ready;

endmodule

/* rtl/srdg_ctrl.sv */
module srdg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  srdg_pkg::status_t   status,
  output srdg_pkg::cmd_t      cmd
);
  import srdg_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status.need_div) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end else begin
          state_next = ST_WRITE;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
